[rtl/core/qoi_pkg.sv]
package qoi_pkg;

   localparam int unsigned TABLE_DEPTH = 64;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   // write port of the seen-pixel table
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      pixel_type        px;
   } table_wr_type;

   localparam pixel_type RESET_PIXEL = pixel_type'(32'h0000_00FF);

   localparam logic [7:0] OP_RGB  = 8'b1111_1110;
   localparam logic [7:0] OP_RGBA = 8'b1111_1111;

   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;

   // (3r + 5g + 7b + 11a) mod 64: only the low six bits of each channel matter
   function automatic logic [IDX_W-1:0] pixel_hash(input pixel_type px);
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] g;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] a;
      r = px.red[IDX_W-1:0];
      g = px.green[IDX_W-1:0];
      b = px.blue[IDX_W-1:0];
      a = px.alpha[IDX_W-1:0];
      return IDX_W'(r * IDX_W'(3) + g * IDX_W'(5) + b * IDX_W'(7) + a * IDX_W'(11));
   endfunction

endpackage

[rtl/core/qoi_chunk_decoder_top.sv]
// QOI chunk decoder: takes the chunk stream that follows the image header, one byte per
// beat, and returns RGBA pixels. A byte is taken every cycle while results flow freely;
// a byte that opens an op or carries a payload byte other than the last gives no pixel,
// a run byte gives 1 to 62 pixels and holds the input until its last pixel is given,
// and every other completing byte gives one pixel. A pixel is built in the decode stage
// and held in the result register. The 64-entry table of seen pixels sits in a
// synchronous RAM read when the byte is taken; the pending write of the previous pixel is
// forwarded. image_start clears the previous pixel and the whole table in the same cycle
// through per-entry flags, so no clearing pass is needed after reset or between images.
// run_last marks the final pixel of a byte.
module qoi_chunk_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_image_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   output logic       rsp_run_last
);

   typedef enum logic [1:0] {PEND_NONE, PEND_RGB, PEND_RGBA, PEND_LUMA} pend_type;
   typedef enum logic [2:0] {
      KIND_NONE, KIND_INDEX, KIND_DIFF, KIND_LUMA, KIND_RGB, KIND_RGBA, KIND_RUN
   } kind_type;

   localparam int unsigned IDX_W = qoi_pkg::IDX_W;

   // op assembly
   pend_type                 pend_ff, pend_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [31:0]              pay_ff, pay_in;

   // decode stage
   logic                     s1_vld_ff, s1_vld_in;
   kind_type                 s1_kind_ff;
   logic [31:0]              s1_data_ff;
   logic                     s1_start_ff;
   logic [IDX_W-1:0]         s1_run_ff;

   qoi_pkg::pixel_type       prior_ff, prior_in;

   // table write-back
   logic                     wb_vld_ff, wb_vld_in;
   qoi_pkg::pixel_type       wb_px_ff;
   logic [IDX_W-1:0]         wb_hash_ff;

   // result register
   logic                     out_vld_ff, out_vld_in;
   qoi_pkg::pixel_type       out_px_ff;
   logic                     out_last_ff;

   logic                     accept;
   pend_type                 pend_cur;
   logic [2:0]               cnt_cur, cnt_next, need;
   logic [31:0]              pay_cur, pay_next;
   kind_type                 dec_kind;

   qoi_pkg::pixel_type       base_px, lookup_px, px, rd_data;
   logic                     rd_hit;
   logic [7:0]               luma_dg;
   logic                     o_free, emit, run_end, s1_done;
   qoi_pkg::table_wr_type    tbl_wr;

   assign accept = req_valid && !req_stall;

   // byte decode and payload collection
   always_comb begin
      pend_cur = req_image_start ? PEND_NONE : pend_ff;
      cnt_cur  = req_image_start ? 3'd0 : cnt_ff;
      pay_cur  = req_image_start ? 32'd0 : pay_ff;
      pay_next = {pay_cur[23:0], req_data_byte};
      cnt_next = cnt_cur + 3'd1;
      unique case (pend_cur)
         PEND_RGB:  need = 3'd3;
         PEND_RGBA: need = 3'd4;
         default:   need = 3'd1;
      endcase
      dec_kind = KIND_NONE;
      pend_in  = pend_cur;
      cnt_in   = cnt_cur;
      pay_in   = pay_cur;
      if (pend_cur != PEND_NONE) begin
         if (cnt_next == need) begin
            unique case (pend_cur)
               PEND_RGB:  dec_kind = KIND_RGB;
               PEND_RGBA: dec_kind = KIND_RGBA;
               default:   dec_kind = KIND_LUMA;
            endcase
            pend_in = PEND_NONE;
            cnt_in  = 3'd0;
            pay_in  = 32'd0;
         end else begin
            cnt_in = cnt_next;
            pay_in = pay_next;
         end
      end else if (req_data_byte == qoi_pkg::OP_RGB) begin
         pend_in = PEND_RGB;
         cnt_in  = 3'd0;
         pay_in  = 32'd0;
      end else if (req_data_byte == qoi_pkg::OP_RGBA) begin
         pend_in = PEND_RGBA;
         cnt_in  = 3'd0;
         pay_in  = 32'd0;
      end else begin
         unique case (req_data_byte[7:6])
            qoi_pkg::TAG_INDEX: dec_kind = KIND_INDEX;
            qoi_pkg::TAG_DIFF:  dec_kind = KIND_DIFF;
            qoi_pkg::TAG_LUMA: begin
               pend_in = PEND_LUMA;
               cnt_in  = 3'd0;
               pay_in  = {26'd0, req_data_byte[5:0]};
            end
            default:            dec_kind = KIND_RUN;
         endcase
      end
      if (!accept) begin
         pend_in = pend_ff;
         cnt_in  = cnt_ff;
         pay_in  = pay_ff;
      end
   end

   // pixel build
   always_comb begin
      base_px = s1_start_ff ? qoi_pkg::RESET_PIXEL : prior_ff;
      if (wb_vld_ff && (wb_hash_ff == s1_data_ff[IDX_W-1:0])) begin
         lookup_px = wb_px_ff;
      end else if (rd_hit) begin
         lookup_px = rd_data;
      end else begin
         lookup_px = '0;
      end
      luma_dg = {2'b00, s1_data_ff[13:8]} - 8'd32;
      px      = base_px;
      unique case (s1_kind_ff)
         KIND_INDEX: px = lookup_px;
         KIND_DIFF: begin
            px.red   = base_px.red   + {6'd0, s1_data_ff[5:4]} - 8'd2;
            px.green = base_px.green + {6'd0, s1_data_ff[3:2]} - 8'd2;
            px.blue  = base_px.blue  + {6'd0, s1_data_ff[1:0]} - 8'd2;
         end
         KIND_LUMA: begin
            px.red   = base_px.red   + luma_dg + {4'd0, s1_data_ff[7:4]} - 8'd8;
            px.green = base_px.green + luma_dg;
            px.blue  = base_px.blue  + luma_dg + {4'd0, s1_data_ff[3:0]} - 8'd8;
         end
         KIND_RGB: begin
            px.red   = s1_data_ff[23:16];
            px.green = s1_data_ff[15:8];
            px.blue  = s1_data_ff[7:0];
         end
         KIND_RGBA: px = qoi_pkg::pixel_type'(s1_data_ff);
         default:   px = base_px;
      endcase
   end

   assign o_free    = !out_vld_ff || !rsp_stall;
   assign run_end   = (s1_kind_ff != KIND_RUN) || (s1_run_ff == '0);
   assign emit      = s1_vld_ff && (s1_kind_ff != KIND_NONE) && o_free;
   assign s1_done   = s1_vld_ff && ((s1_kind_ff == KIND_NONE) || (o_free && run_end));
   assign req_stall = s1_vld_ff && !s1_done;

   always_comb begin
      s1_vld_in  = accept ? 1'b1 : (s1_done ? 1'b0 : s1_vld_ff);
      prior_in   = s1_done ? px : prior_ff;
      // drop a write-back of the old image when a new one starts
      wb_vld_in  = s1_done && (s1_kind_ff != KIND_NONE) && !(accept && req_image_start);
      out_vld_in = emit ? 1'b1 : (rsp_stall ? out_vld_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= PEND_NONE;
         cnt_ff     <= 3'd0;
         pay_ff     <= 32'd0;
         s1_vld_ff  <= 1'b0;
         prior_ff   <= qoi_pkg::RESET_PIXEL;
         wb_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         cnt_ff     <= cnt_in;
         pay_ff     <= pay_in;
         s1_vld_ff  <= s1_vld_in;
         prior_ff   <= prior_in;
         wb_vld_ff  <= wb_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= dec_kind;
         s1_data_ff  <= pay_next;
         s1_start_ff <= req_image_start;
         s1_run_ff   <= req_data_byte[IDX_W-1:0];
      end else if (emit && !run_end) begin
         s1_run_ff <= s1_run_ff - IDX_W'(1);
      end
      wb_px_ff   <= px;
      wb_hash_ff <= qoi_pkg::pixel_hash(px);
      if (emit) begin
         out_px_ff   <= px;
         out_last_ff <= run_end;
      end
   end

   assign tbl_wr.en   = wb_vld_ff;
   assign tbl_wr.addr = wb_hash_ff;
   assign tbl_wr.px   = wb_px_ff;

   qoi_table u_table (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept && req_image_start),
      .rd_en   (accept),
      .rd_addr (req_data_byte[IDX_W-1:0]),
      .wr      (tbl_wr),
      .rd_data (rd_data),
      .rd_hit  (rd_hit)
   );

   assign rsp_valid    = out_vld_ff;
   assign rsp_red      = out_px_ff.red;
   assign rsp_green    = out_px_ff.green;
   assign rsp_blue     = out_px_ff.blue;
   assign rsp_alpha    = out_px_ff.alpha;
   assign rsp_run_last = out_last_ff;

   // a beat that is not the last of its byte means the run is still in the decode stage
   a_run_held: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_last_ff) |-> (s1_vld_ff && (s1_kind_ff == KIND_RUN)))
      else $error("run beat without a run in progress");

   // an index byte that starts an image sees an empty table
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_start_ff && (s1_kind_ff == KIND_INDEX)) |-> (lookup_px == '0))
      else $error("stale table entry seen after image start");

   // no leftover payload once no op is collecting
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == PEND_NONE) |-> ((cnt_ff == 3'd0) && (pay_ff == 32'd0)))
      else $error("payload left without a pending op");

   // the pixel headed for the table is the one just made current
   a_wb_prior: assert property (@(posedge clock) disable iff (reset)
      wb_vld_ff |-> (wb_px_ff == prior_ff))
      else $error("table write differs from previous pixel");

endmodule

[rtl/core/qoi_table.sv]
module qoi_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        rd_en,
   input  logic [qoi_pkg::IDX_W-1:0]   rd_addr,
   input  qoi_pkg::table_wr_type       wr,
   output qoi_pkg::pixel_type          rd_data,
   output logic                        rd_hit
);

   qoi_pkg::pixel_type               mem [qoi_pkg::TABLE_DEPTH];
   logic [qoi_pkg::TABLE_DEPTH-1:0]  vld_ff;
   logic [qoi_pkg::IDX_W-1:0]        addr_ff;
   qoi_pkg::pixel_type               data_ff;
   logic                             hit_ff;
   logic                             wr_rd_match;
   logic                             wr_held_match;

   assign wr_rd_match   = wr.en && (wr.addr == rd_addr);
   assign wr_held_match = wr.en && (wr.addr == addr_ff);

   // entry flags: a flag that is clear reads as an all-zero pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (clear) begin
            vld_ff <= '0;
         end else if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= !clear && (vld_ff[rd_addr] || wr_rd_match);
         end else if (wr_held_match) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // write-first read; keep the held read word fresh while the reader waits
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.px;
      end
      if (rd_en) begin
         addr_ff <= rd_addr;
         data_ff <= wr_rd_match ? wr.px : mem[rd_addr];
      end else if (wr_held_match) begin
         data_ff <= wr.px;
      end
   end

   assign rd_data = data_ff;
   assign rd_hit  = hit_ff;

endmodule

[sim/qoi_chunk_decoder_top_test.sv]
module qoi_chunk_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BYTES = 400;
   localparam int unsigned QUIET_FROM   = 360;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 10;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_RGB,
      PEND_RGBA,
      PEND_LUMA
   } pend_op_type;

   typedef struct {
      qoi_pkg::pixel_type px;
      logic               is_last;
   } owed_pixel_type;

   class pixel_scoreboard;
      qoi_pkg::pixel_type prior;
      qoi_pkg::pixel_type seen [qoi_pkg::TABLE_DEPTH];
      pend_op_type        pend;
      int unsigned        held;
      logic [31:0]        payload;
      owed_pixel_type     owed_pixels [$];
      int unsigned        errors;

      function new();
         errors = 0;
         clear_image();
      endfunction

      function void clear_image();
         prior = qoi_pkg::RESET_PIXEL;
         foreach (seen[i]) seen[i] = '0;
         pend    = PEND_NONE;
         held    = 0;
         payload = '0;
      endfunction

      function logic [qoi_pkg::IDX_W-1:0] slot(qoi_pkg::pixel_type p);
         logic [31:0] sum;
         sum = 3 * p.red + 5 * p.green + 7 * p.blue + 11 * p.alpha;
         return sum[qoi_pkg::IDX_W-1:0];
      endfunction

      function void owe(qoi_pkg::pixel_type p, logic is_last);
         owed_pixel_type item;
         item.px      = p;
         item.is_last = is_last;
         owed_pixels.push_back(item);
      endfunction

      // note one accepted byte and queue the pixels it decodes to
      function void decode_byte(logic [7:0] b, logic start);
         qoi_pkg::pixel_type px;
         int unsigned        need;
         logic [7:0]         dg;
         int                 n;
         int                 k;
         if (start) clear_image();
         px = prior;
         if (pend != PEND_NONE) begin
            need    = (pend == PEND_RGB) ? 3 : (pend == PEND_RGBA) ? 4 : 1;
            payload = {payload[23:0], b};
            held++;
            if (held < need) return;
            case (pend)
               PEND_RGB: begin
                  px.red   = payload[23:16];
                  px.green = payload[15:8];
                  px.blue  = payload[7:0];
               end
               PEND_RGBA: px = payload;
               default: begin
                  dg       = {2'b00, payload[13:8]} - 8'd32;
                  px.green = prior.green + dg;
                  px.red   = prior.red + dg + {4'b0000, payload[7:4]} - 8'd8;
                  px.blue  = prior.blue + dg + {4'b0000, payload[3:0]} - 8'd8;
               end
            endcase
            pend    = PEND_NONE;
            held    = 0;
            payload = '0;
         end else if (b == qoi_pkg::OP_RGB || b == qoi_pkg::OP_RGBA) begin
            pend    = (b == qoi_pkg::OP_RGB) ? PEND_RGB : PEND_RGBA;
            held    = 0;
            payload = '0;
            return;
         end else begin
            case (b[7:6])
               qoi_pkg::TAG_INDEX: px = seen[b[5:0]];
               qoi_pkg::TAG_DIFF: begin
                  px.red   = prior.red + {6'b0, b[5:4]} - 8'd2;
                  px.green = prior.green + {6'b0, b[3:2]} - 8'd2;
                  px.blue  = prior.blue + {6'b0, b[1:0]} - 8'd2;
               end
               qoi_pkg::TAG_LUMA: begin
                  pend    = PEND_LUMA;
                  held    = 0;
                  payload = {26'b0, b[5:0]};
                  return;
               end
               default: begin
                  // run: repeat the previous pixel, table still gets it
                  seen[slot(px)] = px;
                  n = int'(b[5:0]) + 1;
                  for (k = 0; k < n; k++) owe(px, k == n - 1);
                  return;
               end
            endcase
         end
         prior          = px;
         seen[slot(px)] = px;
         owe(px, 1'b1);
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_pixel(qoi_pkg::pixel_type got, logic got_last);
         owed_pixel_type want;
         if (owed_pixels.size() == 0) begin
            $display("%0t: pixel with none expected, expected nothing, actual %h last %b",
                     $time, got, got_last);
            errors++;
            return;
         end
         want = owed_pixels.pop_front();
         compare("red", want.px.red, got.red);
         compare("green", want.px.green, got.green);
         compare("blue", want.px.blue, got.blue);
         compare("alpha", want.px.alpha, got.alpha);
         compare("run_last", {7'b0, want.is_last}, {7'b0, got_last});
      endfunction
   endclass

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte   = '0;
   logic       req_image_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_alpha;
   logic       rsp_run_last;

   pixel_scoreboard sb;
   logic            byte_taken;
   logic            pixel_taken;
   int unsigned     idle_cycles = 0;
   int unsigned     bytes_sent  = 0;
   int unsigned     gap_odds    = 2;
   int unsigned     stall_odds  = 2;
   int unsigned     stall_left  = 0;
   bit              quiet       = 1'b0;

   qoi_chunk_decoder_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_run_last    (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   assign byte_taken  = req_valid && !req_stall;
   assign pixel_taken = rsp_valid && !rsp_stall;

   always @(posedge clock) begin
      if (!reset) begin
         if (byte_taken) sb.decode_byte(req_data_byte, req_image_start);
         if (pixel_taken) begin
            sb.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_alpha}, rsp_run_last);
         end
         idle_cycles <= (byte_taken || pixel_taken) ? 0 : idle_cycles + 1;
      end
   end

   // stall the pixel side in bursts held while stall_left counts down from a random start
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) < stall_odds) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("qoi_chunk_decoder_top test failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      if (!quiet && $urandom_range(0, 9) < gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_image_start <= start;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
      if (bytes_sent % 40 == 0) begin
         gap_odds   = $urandom_range(0, 3);
         stall_odds = $urandom_range(0, 4);
      end
      if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
   endtask

   task automatic send_random_op();
      int unsigned               pick;
      logic                      start;
      logic [qoi_pkg::IDX_W-1:0] idx;
      logic [5:0]                len;
      start = ($urandom_range(0, 39) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 12) begin
         send_byte(qoi_pkg::OP_RGB, start);
         repeat (3) send_byte(8'($urandom), 1'b0);
      end else if (pick < 22) begin
         send_byte(qoi_pkg::OP_RGBA, start);
         repeat (4) send_byte(8'($urandom), 1'b0);
      end else if (pick < 38) begin
         // aim at the slot of the current pixel half the time so hits are real
         idx = $urandom_range(0, 1) ? sb.slot(sb.prior) : qoi_pkg::IDX_W'($urandom);
         send_byte({qoi_pkg::TAG_INDEX, idx}, start);
      end else if (pick < 56) begin
         send_byte({qoi_pkg::TAG_DIFF, 6'($urandom)}, start);
      end else if (pick < 72) begin
         send_byte({qoi_pkg::TAG_LUMA, 6'($urandom)}, start);
         send_byte(8'($urandom), 1'b0);
      end else if (pick < 88) begin
         len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(8, 61))
                                           : 6'($urandom_range(0, 7));
         send_byte({qoi_pkg::TAG_RUN, len}, start);
      end else if (pick < 94) begin
         // broken op: cut short by a new image
         send_byte($urandom_range(0, 1) ? qoi_pkg::OP_RGBA : qoi_pkg::OP_RGB, start);
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
         send_byte(8'($urandom), 1'b1);
      end else begin
         send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(qoi_pkg::OP_RGB, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(qoi_pkg::OP_RGBA, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte({qoi_pkg::TAG_DIFF, 6'h00}, 1'b0);
      send_byte({qoi_pkg::TAG_DIFF, 6'h3F}, 1'b0);
      send_byte({qoi_pkg::TAG_LUMA, 6'h00}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte({qoi_pkg::TAG_LUMA, 6'h3F}, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({qoi_pkg::TAG_INDEX, 6'd0}, 1'b0);
      send_byte({qoi_pkg::TAG_INDEX, 6'd63}, 1'b0);
      send_byte({qoi_pkg::TAG_RUN, 6'd0}, 1'b0);
      send_byte({qoi_pkg::TAG_RUN, 6'd61}, 1'b0);
      send_byte(qoi_pkg::OP_RGBA, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      send_byte({qoi_pkg::TAG_INDEX, 6'd1}, 1'b0);

      while (bytes_sent < RANDOM_BYTES + 23) send_random_op();
      req_valid <= 1'b0;

      while (sb.owed_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.owed_pixels.size() == 0) begin
         $display("qoi_chunk_decoder_top test passed");
      end else begin
         $display("qoi_chunk_decoder_top test failed");
      end
      $finish;
   end

endmodule
